/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL of the illumination gain regulator.
// Depends on nothing; the including module must have clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is active.
`define IGR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Clocked check that also applies during reset.
`define IGR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

/* hdl/igr_pkg.sv */
// Shared types, widths and codes of the illumination gain regulator.
// Depends on nothing; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package igr_pkg;

  // Field widths
  localparam int NumLamps  = 8;
  localparam int LampW     = 16;
  localparam int PeakW     = 8;
  localparam int TargetW   = 8;
  localparam int TolW      = 8;
  localparam int GainW     = 12;
  localparam int ModeW     = 2;
  localparam int StatusW   = 2;
  localparam int IndexW    = 3;
  localparam int ErrW      = PeakW + 1;
  localparam int ProdW     = ErrW + GainW;
  localparam int FracW     = 8;
  localparam int SumW      = LampW + FracW + 2;
  localparam int LvlW      = SumW - 1 - FracW;

  // Configuration port
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 16;

  // Counters and their limits
  localparam int SettleW      = 3;
  localparam int AttemptW     = 6;
  localparam int SettleLimit  = 5;
  localparam int AttemptLimit = 40;

  // Lamp clamp floor and the reciprocal used for division by five
  localparam int LampFloor   = 100;
  localparam int Recip5      = 52429;
  localparam int Recip5Shift = 18;
  localparam int FifthW      = LampW - 2;

  // Lamp layout: four colors per sensor, top sensor first
  localparam int NumSensors   = 2;
  localparam int SensorStride = 4;
  localparam int TopBase      = 0;
  localparam int BottomBase   = SensorStride;
  localparam int OffRed       = 0;
  localparam int OffGreen     = 1;
  localparam int OffBlue      = 2;
  localparam int OffIr        = 3;

  // Reset values of the registers
  localparam logic [TargetW-1:0] TargetReset = 8'd237;
  localparam logic [TolW-1:0]    TolReset    = 8'd8;
  localparam logic [GainW-1:0]   GainReset   = 12'd512;
  localparam logic [LampW-1:0]   MaxReset    = 16'd4000;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTarget    = 3'd0,
    CfgTolerance = 3'd1,
    CfgGain      = 3'd2,
    CfgMax       = 3'd3,
    CfgMode      = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    KindLoad    = 1'b0,
    KindMeasure = 1'b1
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    StatusContinue  = 2'd0,
    StatusConverged = 2'd1,
    StatusTimeout   = 2'd2
  } status_e;

  typedef enum logic [ModeW-1:0] {
    ModeColor = 2'd0,
    ModeGray  = 2'd1,
    ModeIr    = 2'd2,
    ModeRaw   = 2'd3
  } mode_e;

  typedef logic [LampW-1:0]                  lamp_t;
  typedef logic [NumLamps-1:0][LampW-1:0]    lamps_t;
  typedef logic [NumLamps-1:0][PeakW-1:0]    peaks_t;

endpackage

/* hdl/igr_in_if.sv */
// Input channel of the illumination gain regulator: valid/ready plus one item.
// Depends on igr_pkg for field widths.
`timescale 1ns / 1ps

interface igr_in_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [igr_pkg::IndexW-1:0]   lamp_index;
  logic [igr_pkg::LampW-1:0]    lamp_value;
  logic [igr_pkg::PeakW-1:0]    peak_top_red;
  logic [igr_pkg::PeakW-1:0]    peak_top_green;
  logic [igr_pkg::PeakW-1:0]    peak_top_blue;
  logic [igr_pkg::PeakW-1:0]    peak_top_ir;
  logic [igr_pkg::PeakW-1:0]    peak_bottom_red;
  logic [igr_pkg::PeakW-1:0]    peak_bottom_green;
  logic [igr_pkg::PeakW-1:0]    peak_bottom_blue;
  logic [igr_pkg::PeakW-1:0]    peak_bottom_ir;

  modport source (
    output valid, kind, lamp_index, lamp_value,
           peak_top_red, peak_top_green, peak_top_blue, peak_top_ir,
           peak_bottom_red, peak_bottom_green, peak_bottom_blue, peak_bottom_ir,
    input  ready
  );

  modport sink (
    input  valid, kind, lamp_index, lamp_value,
           peak_top_red, peak_top_green, peak_top_blue, peak_top_ir,
           peak_bottom_red, peak_bottom_green, peak_bottom_blue, peak_bottom_ir,
    output ready
  );
endinterface

/* hdl/igr_out_if.sv */
// Result channel of the illumination gain regulator: valid/ready plus one result.
// Depends on igr_pkg for field widths.
`timescale 1ns / 1ps

interface igr_out_if;
  logic                         valid;
  logic                         ready;
  logic [igr_pkg::StatusW-1:0]  status;
  logic [igr_pkg::LampW-1:0]    lamp_top_red;
  logic [igr_pkg::LampW-1:0]    lamp_top_green;
  logic [igr_pkg::LampW-1:0]    lamp_top_blue;
  logic [igr_pkg::LampW-1:0]    lamp_top_ir;
  logic [igr_pkg::LampW-1:0]    lamp_bottom_red;
  logic [igr_pkg::LampW-1:0]    lamp_bottom_green;
  logic [igr_pkg::LampW-1:0]    lamp_bottom_blue;
  logic [igr_pkg::LampW-1:0]    lamp_bottom_ir;

  modport source (
    output valid, status,
           lamp_top_red, lamp_top_green, lamp_top_blue, lamp_top_ir,
           lamp_bottom_red, lamp_bottom_green, lamp_bottom_blue, lamp_bottom_ir,
    input  ready
  );

  modport sink (
    input  valid, status,
           lamp_top_red, lamp_top_green, lamp_top_blue, lamp_top_ir,
           lamp_bottom_red, lamp_bottom_green, lamp_bottom_blue, lamp_bottom_ir,
    output ready
  );
endinterface

/* hdl/illumination_gain_regulator.sv */
// Illumination gain regulator: proportional control of eight lamp intensities
// (R, G, B, IR for a top and a bottom sensor). A load beat writes one lamp and
// clears the settle and attempt counters; a measurement beat moves every lamp by
// (target - peak) * gain in Q4.8, clamps it to [100, max_intensity] and applies
// the color mode, unless the loop has already converged or timed out. Every beat
// gives exactly one result beat. Throughput is one beat per clock while the
// result side is not stalled: the input register holds the beat with the error
// products already formed, and the lamp update, clamp, mode rules and counters
// settle in one pass into the lamp state and the result register. Depends on
// igr_pkg, igr_in_if, igr_out_if and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module illumination_gain_regulator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [igr_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [igr_pkg::CfgDataW-1:0]  cfg_data_i,
  igr_in_if.sink                        in_i,
  igr_out_if.source                     out_o
);

  // Configuration registers
  logic [igr_pkg::TargetW-1:0] target_q;
  logic [igr_pkg::TolW-1:0]    tol_q;
  logic [igr_pkg::GainW-1:0]   gain_q;
  igr_pkg::lamp_t              max_q;
  igr_pkg::mode_e              mode_q;

  // Input stage
  logic                          in_valid_q;
  igr_pkg::kind_e                kind_q;
  logic [igr_pkg::IndexW-1:0]    idx_q;
  igr_pkg::lamp_t                value_q;
  logic signed [igr_pkg::ProdW-1:0] prod_d [igr_pkg::NumLamps];
  logic signed [igr_pkg::ProdW-1:0] prod_q [igr_pkg::NumLamps];
  logic [igr_pkg::NumLamps-1:0]  beyond_d;
  logic [igr_pkg::NumLamps-1:0]  beyond_q;
  igr_pkg::peaks_t               peak_in;

  // Regulator state
  igr_pkg::lamps_t               lamp_q;
  igr_pkg::lamps_t               lamp_d;
  logic [igr_pkg::SettleW-1:0]   settle_q;
  logic [igr_pkg::SettleW-1:0]   settle_d;
  logic [igr_pkg::AttemptW-1:0]  attempt_q;
  logic [igr_pkg::AttemptW-1:0]  attempt_d;

  // Result register
  logic                          out_valid_q;
  igr_pkg::status_e              status_q;
  igr_pkg::status_e              status_d;
  igr_pkg::lamps_t               out_lamps_q;

  // Update path
  logic                          advance;
  logic                          in_fire;
  igr_pkg::lamps_t               adj_lamps;
  igr_pkg::lamps_t               ruled_lamps;
  logic                          settle_clear;
  logic [igr_pkg::SettleW-1:0]   settle_inc;
  logic [igr_pkg::AttemptW-1:0]  attempt_inc;
  logic [31:0]                   recip_prod [igr_pkg::NumSensors];
  logic [igr_pkg::FifthW-1:0]    fifth [igr_pkg::NumSensors];
  igr_pkg::lamp_t                fifth_rest [igr_pkg::NumSensors];
  igr_pkg::lamp_t                gray_green [igr_pkg::NumSensors];
  igr_pkg::lamp_t                gray_blue [igr_pkg::NumSensors];

  // New lamp level: L*256 + e*gain, floor to 100 when negative, clamp both ends
  function automatic igr_pkg::lamp_t adjust_lamp(
    igr_pkg::lamp_t                   lamp,
    logic signed [igr_pkg::ProdW-1:0] prod,
    igr_pkg::lamp_t                   max_lim
  );
    logic signed [igr_pkg::SumW-1:0] sum;
    logic [igr_pkg::LvlW-1:0]        lvl;
    sum = $signed({{(igr_pkg::SumW - igr_pkg::LampW - igr_pkg::FracW){1'b0}},
                   lamp, {igr_pkg::FracW{1'b0}}})
        + igr_pkg::SumW'(prod);
    if (sum[igr_pkg::SumW-1]) begin
      lvl = igr_pkg::LvlW'(igr_pkg::LampFloor);
    end else begin
      lvl = sum[igr_pkg::SumW-2:igr_pkg::FracW];
    end
    if (lvl < igr_pkg::LvlW'(igr_pkg::LampFloor)) begin
      lvl = igr_pkg::LvlW'(igr_pkg::LampFloor);
    end
    if (lvl > igr_pkg::LvlW'(max_lim)) begin
      lvl = igr_pkg::LvlW'(max_lim);
    end
    return lvl[igr_pkg::LampW-1:0];
  endfunction

  // floor(4*rem/5) for a remainder of division by five
  function automatic logic [1:0] four_fifths_rest(logic [2:0] rem);
    logic [1:0] res;
    case (rem) inside
      3'd2:    res = 2'd1;
      3'd3:    res = 2'd2;
      3'd4:    res = 2'd3;
      default: res = 2'd0;
    endcase
    return res;
  endfunction

  // floor(3*rem/5) for a remainder of division by five
  function automatic logic [1:0] three_fifths_rest(logic [2:0] rem);
    logic [1:0] res;
    case (rem) inside
      3'd2, 3'd3: res = 2'd1;
      3'd4:       res = 2'd2;
      default:    res = 2'd0;
    endcase
    return res;
  endfunction

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= igr_pkg::TargetReset;
      tol_q    <= igr_pkg::TolReset;
      gain_q   <= igr_pkg::GainReset;
      max_q    <= igr_pkg::MaxReset;
      mode_q   <= igr_pkg::ModeColor;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        igr_pkg::CfgTarget:    target_q <= cfg_data_i[igr_pkg::TargetW-1:0];
        igr_pkg::CfgTolerance: tol_q    <= cfg_data_i[igr_pkg::TolW-1:0];
        igr_pkg::CfgGain:      gain_q   <= cfg_data_i[igr_pkg::GainW-1:0];
        igr_pkg::CfgMax:       max_q    <= cfg_data_i[igr_pkg::LampW-1:0];
        igr_pkg::CfgMode:      mode_q   <= igr_pkg::mode_e'(cfg_data_i[igr_pkg::ModeW-1:0]);
        default: ;
      endcase
    end
  end

  // Handshake: advance when the result register is free or being drained
  assign advance  = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;
  assign in_fire  = in_i.valid && in_i.ready;

  // Gather the peak fields in lamp order
  assign peak_in[igr_pkg::TopBase + igr_pkg::OffRed]      = in_i.peak_top_red;
  assign peak_in[igr_pkg::TopBase + igr_pkg::OffGreen]    = in_i.peak_top_green;
  assign peak_in[igr_pkg::TopBase + igr_pkg::OffBlue]     = in_i.peak_top_blue;
  assign peak_in[igr_pkg::TopBase + igr_pkg::OffIr]       = in_i.peak_top_ir;
  assign peak_in[igr_pkg::BottomBase + igr_pkg::OffRed]   = in_i.peak_bottom_red;
  assign peak_in[igr_pkg::BottomBase + igr_pkg::OffGreen] = in_i.peak_bottom_green;
  assign peak_in[igr_pkg::BottomBase + igr_pkg::OffBlue]  = in_i.peak_bottom_blue;
  assign peak_in[igr_pkg::BottomBase + igr_pkg::OffIr]    = in_i.peak_bottom_ir;

  // Form error products and tolerance flags as the beat enters
  always_comb begin
    logic signed [igr_pkg::ErrW-1:0] err;
    logic [igr_pkg::ErrW-1:0]        mag;
    for (int i = 0; i < igr_pkg::NumLamps; i++) begin
      err = $signed({1'b0, target_q}) - $signed({1'b0, peak_in[i]});
      prod_d[i] = igr_pkg::ProdW'(err) * igr_pkg::ProdW'($signed({1'b0, gain_q}));
      mag = err[igr_pkg::ErrW-1] ? igr_pkg::ErrW'(-err) : igr_pkg::ErrW'(err);
      beyond_d[i] = mag > {1'b0, tol_q};
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q   <= igr_pkg::kind_e'(in_i.kind);
      idx_q    <= in_i.lamp_index;
      value_q  <= in_i.lamp_value;
      prod_q   <= prod_d;
      beyond_q <= beyond_d;
    end
  end

  // Proportional step with clamp on every lamp
  always_comb begin
    for (int i = 0; i < igr_pkg::NumLamps; i++) begin
      adj_lamps[i] = adjust_lamp(lamp_q[i], prod_q[i], max_q);
    end
  end

  // Gray mode: green = floor(4r/5), blue = floor(3r/5) from r/5 and remainder
  always_comb begin
    igr_pkg::lamp_t red;
    for (int s = 0; s < igr_pkg::NumSensors; s++) begin
      red = adj_lamps[s * igr_pkg::SensorStride + igr_pkg::OffRed];
      recip_prod[s] = 32'(red) * 32'(igr_pkg::Recip5);
      fifth[s] = recip_prod[s][igr_pkg::Recip5Shift +: igr_pkg::FifthW];
      fifth_rest[s] = red - ({fifth[s], 2'b00} + {2'b00, fifth[s]});
      gray_green[s] = {fifth[s], 2'b00}
                    + {{(igr_pkg::LampW-2){1'b0}}, four_fifths_rest(fifth_rest[s][2:0])};
      gray_blue[s] = {1'b0, fifth[s], 1'b0} + {2'b00, fifth[s]}
                   + {{(igr_pkg::LampW-2){1'b0}}, three_fifths_rest(fifth_rest[s][2:0])};
    end
  end

  // Apply the color mode and pick the channels that watch the tolerance
  always_comb begin
    int b;
    ruled_lamps  = adj_lamps;
    settle_clear = 1'b0;
    for (int s = 0; s < igr_pkg::NumSensors; s++) begin
      b = s * igr_pkg::SensorStride;
      case (mode_q)
        igr_pkg::ModeColor: begin
          if (beyond_q[b + igr_pkg::OffRed] || beyond_q[b + igr_pkg::OffGreen]
              || beyond_q[b + igr_pkg::OffBlue]) begin
            settle_clear = 1'b1;
          end
          ruled_lamps[b + igr_pkg::OffIr] = '0;
        end
        igr_pkg::ModeGray: begin
          if (beyond_q[b + igr_pkg::OffRed]) begin
            settle_clear = 1'b1;
          end
          ruled_lamps[b + igr_pkg::OffGreen] = gray_green[s];
          ruled_lamps[b + igr_pkg::OffBlue]  = gray_blue[s];
          ruled_lamps[b + igr_pkg::OffIr]    = '0;
        end
        igr_pkg::ModeIr: begin
          if (beyond_q[b + igr_pkg::OffIr]) begin
            settle_clear = 1'b1;
          end
          ruled_lamps[b + igr_pkg::OffRed]   = '0;
          ruled_lamps[b + igr_pkg::OffGreen] = '0;
          ruled_lamps[b + igr_pkg::OffBlue]  = '0;
        end
        default: ;
      endcase
    end
  end

  // Saturating counter increments
  assign settle_inc  = (&settle_q)  ? settle_q  : settle_q + 1'b1;
  assign attempt_inc = (&attempt_q) ? attempt_q : attempt_q + 1'b1;

  // Next state and status for the beat in the input register
  always_comb begin
    lamp_d    = lamp_q;
    settle_d  = settle_q;
    attempt_d = attempt_q;
    status_d  = igr_pkg::StatusContinue;
    if (kind_q == igr_pkg::KindLoad) begin
      lamp_d[idx_q] = value_q;
      settle_d      = '0;
      attempt_d     = '0;
    end else if (settle_q > igr_pkg::SettleW'(igr_pkg::SettleLimit)) begin
      settle_d = settle_inc;
      status_d = igr_pkg::StatusConverged;
    end else if (attempt_q > igr_pkg::AttemptW'(igr_pkg::AttemptLimit)) begin
      settle_d  = settle_inc;
      attempt_d = attempt_inc;
      status_d  = igr_pkg::StatusTimeout;
    end else begin
      settle_d  = settle_clear ? '0 : settle_inc;
      attempt_d = attempt_inc;
      lamp_d    = ruled_lamps;
    end
  end

  // Regulator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lamp_q    <= '0;
      settle_q  <= '0;
      attempt_q <= '0;
    end else if (advance) begin
      lamp_q    <= lamp_d;
      settle_q  <= settle_d;
      attempt_q <= attempt_d;
    end
  end

  // Result register: load on advance, drop once the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      status_q    <= status_d;
      out_lamps_q <= lamp_d;
    end
  end

  // Drive the result channel
  assign out_o.valid             = out_valid_q;
  assign out_o.status            = status_q;
  assign out_o.lamp_top_red      = out_lamps_q[igr_pkg::TopBase + igr_pkg::OffRed];
  assign out_o.lamp_top_green    = out_lamps_q[igr_pkg::TopBase + igr_pkg::OffGreen];
  assign out_o.lamp_top_blue     = out_lamps_q[igr_pkg::TopBase + igr_pkg::OffBlue];
  assign out_o.lamp_top_ir       = out_lamps_q[igr_pkg::TopBase + igr_pkg::OffIr];
  assign out_o.lamp_bottom_red   = out_lamps_q[igr_pkg::BottomBase + igr_pkg::OffRed];
  assign out_o.lamp_bottom_green = out_lamps_q[igr_pkg::BottomBase + igr_pkg::OffGreen];
  assign out_o.lamp_bottom_blue  = out_lamps_q[igr_pkg::BottomBase + igr_pkg::OffBlue];
  assign out_o.lamp_bottom_ir    = out_lamps_q[igr_pkg::BottomBase + igr_pkg::OffIr];

  // Checks
  `IGR_ASSERT_RST(a_reset_flush, !rst_ni |-> !out_valid_q && !in_valid_q, "reset left a beat in flight")
  `IGR_ASSERT(a_out_tracks_state, out_valid_q |-> out_lamps_q == lamp_q, "result lamps differ from lamp state")
  `IGR_ASSERT(a_converged_count, out_valid_q && status_q == igr_pkg::StatusConverged |-> settle_q > igr_pkg::SettleW'(igr_pkg::SettleLimit), "converged without settle count past limit")
  `IGR_ASSERT(a_timeout_count, out_valid_q && status_q == igr_pkg::StatusTimeout |-> attempt_q > igr_pkg::AttemptW'(igr_pkg::AttemptLimit), "timed out without attempt count past limit")
  `IGR_ASSERT(a_stall_only_full, !in_i.ready |-> in_valid_q && out_valid_q, "input stalled with a free stage")

endmodule
